// ===== design/gtc_pkg.sv =====
// Shared types, constants and polynomial coefficients for the gravity temperature correction core.
package gtc_pkg;

   localparam int GW = 18;
   localparam int TW = 16;
   localparam int FW = 18;
   localparam int PW = 31;
   localparam int QW = 20;
   localparam int NW = PW + QW;
   localparam int POLY_LAT = 5;

   typedef logic [GW-1:0]        grav_type;
   typedef logic signed [TW-1:0] temp_type;
   typedef logic signed [FW-1:0] fahr_type;
   typedef logic [PW-1:0]        poly_type;
   typedef logic [NW-1:0]        num_type;
   typedef logic [QW-1:0]        quo_type;

   localparam grav_type GMAX = {GW{1'b1}};
   localparam temp_type CAL_RESET = 16'sd5120;

   localparam int RECIP_SHIFT = 22;
   localparam logic [19:0] RECIP5 = 20'(((64'd1 << RECIP_SHIFT) / 64'd5) + 64'd1);
   localparam logic signed [20:0] C_TO_F_BIAS = 21'sd327682;
   localparam logic signed [18:0] F_OFFSET = 19'sd57344;

   localparam logic [63:0] P5_8  = 64'd390625;
   localparam logic [63:0] P5_12 = 64'd244140625;
   localparam logic [63:0] P5_14 = 64'd6103515625;
   localparam logic [63:0] P5_17 = 64'd762939453125;

   localparam logic [63:0] D0 = 64'd100130346 << 22;
   localparam logic [63:0] D1 = 64'd134722124 << 28;
   localparam logic [63:0] D2 = 64'd204052596 << 34;
   localparam logic [63:0] D3 = 64'd232820948 << 20;

   localparam logic [63:0] COEF0 = (D0 / P5_8) + ((D0 % P5_8) + P5_8 / 64'd2) / P5_8;
   localparam logic [63:0] COEF1 = (D1 / P5_12) + ((D1 % P5_12) + P5_12 / 64'd2) / P5_12;
   localparam logic [63:0] COEF2 = (D2 / P5_14) + ((D2 % P5_14) + P5_14 / 64'd2) / P5_14;
   localparam logic [63:0] COEF3 = ((D3 / P5_17) << 19)
                                 + (((D3 % P5_17) << 19) + P5_17 / 64'd2) / P5_17;

   localparam logic signed [31:0] A0 = signed'(32'(COEF0));
   localparam logic signed [28:0] A1 = signed'(29'(COEF1));
   localparam logic signed [30:0] A2 = signed'(31'(COEF2));
   localparam logic signed [28:0] A3 = signed'(29'(COEF3));

endpackage

// ===== design/gtc_poly.sv =====
// Five-stage pipeline that converts a Celsius temperature to Fahrenheit and evaluates the density cubic.
module gtc_poly (
   input  logic              clock,
   input  logic              en,
   input  gtc_pkg::temp_type temp_c,
   output gtc_pkg::poly_type poly
);
   import gtc_pkg::*;

   localparam logic signed [46:0] RND16_M3 = 47'sd32768;
   localparam logic signed [49:0] RND16_M2 = 50'sd32768;
   localparam logic signed [51:0] RND18_M1 = 52'sd131072;

   logic [39:0]        s1_prod_ff, s1_prod_in;
   fahr_type           s2_f_ff, s2_f_in;
   logic signed [46:0] s2_m3_ff, s2_m3_in;
   fahr_type           s3_f_ff;
   logic signed [49:0] s3_m2_ff, s3_m2_in;
   logic signed [51:0] s4_m1_ff, s4_m1_in;
   logic signed [33:0] s5_p_ff, s5_p_in;

   logic signed [20:0] scaled;
   logic [17:0]        fifth;
   logic signed [18:0] fahr_wide;
   logic signed [31:0] h2;
   logic signed [33:0] h1;

   always_comb begin
      scaled     = 21'(temp_c) * 21'sd9 + C_TO_F_BIAS;
      s1_prod_in = 40'(scaled[19:0]) * 40'(RECIP5);

      fifth     = s1_prod_ff[RECIP_SHIFT +: 18];
      fahr_wide = signed'({1'b0, fifth}) - F_OFFSET;
      s2_f_in   = fahr_wide[FW-1:0];
      s2_m3_in  = 47'(A3) * 47'(s2_f_in);

      h2       = 32'(A2) - 32'((s2_m3_ff + RND16_M3) >>> 16);
      s3_m2_in = 50'(s2_f_ff) * 50'(h2);

      h1       = 34'((s3_m2_ff + RND16_M2) >>> 16) - 34'(A1);
      s4_m1_in = 52'(s3_f_ff) * 52'(h1);

      s5_p_in = 34'(A0) + 34'((s4_m1_ff + RND18_M1) >>> 18);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_prod_ff <= s1_prod_in;
         s2_f_ff    <= s2_f_in;
         s2_m3_ff   <= s2_m3_in;
         s3_f_ff    <= s2_f_ff;
         s3_m2_ff   <= s3_m2_in;
         s4_m1_ff   <= s4_m1_in;
         s5_p_ff    <= s5_p_in;
      end
   end

   assign poly = s5_p_ff[PW-1:0];

endmodule

// ===== design/gtc_div.sv =====
// Pipelined restoring divider that retires one quotient bit per stage.
module gtc_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  gtc_pkg::num_type  num,
   input  gtc_pkg::poly_type den,
   output logic              out_valid,
   output gtc_pkg::quo_type  quo
);
   import gtc_pkg::*;

   logic [PW-1:0] rem_ff [QW];
   logic [PW-1:0] rem_in [QW];
   logic [QW-1:0] low_ff [QW];
   logic [QW-1:0] low_in [QW];
   poly_type      den_ff [QW];
   poly_type      den_src [QW];
   logic [QW-1:0] vld_ff, vld_in;

   logic [PW-1:0] rem_src [QW];
   logic [QW-1:0] low_src [QW];
   logic [PW:0]   trial [QW];
   logic [PW:0]   diff [QW];

   always_comb begin
      for (int k = 0; k < QW; k++) begin
         if (k == 0) begin
            rem_src[k] = num[NW-1:QW];
            low_src[k] = num[QW-1:0];
            den_src[k] = den;
            vld_in[k]  = in_valid;
         end else begin
            rem_src[k] = rem_ff[k-1];
            low_src[k] = low_ff[k-1];
            den_src[k] = den_ff[k-1];
            vld_in[k]  = vld_ff[k-1];
         end
         trial[k] = {rem_src[k], low_src[k][QW-1]};
         diff[k]  = trial[k] - {1'b0, den_src[k]};
         if (trial[k] >= {1'b0, den_src[k]}) begin
            rem_in[k] = diff[k][PW-1:0];
            low_in[k] = {low_src[k][QW-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[k][PW-1:0];
            low_in[k] = {low_src[k][QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QW; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            den_ff[k] <= den_src[k];
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign quo       = low_ff[QW-1];

endmodule

// ===== design/gravity_temperature_correction_core.sv =====
// Top level of the hydrometer temperature correction core with its handshake and output skid stage.
//
// Corrects an unsigned Q2.16 gravity reading taken at a signed Q8.8 Celsius temperature to the
// calibration temperature held in the csr register (reset value 20.0 C). The datapath is a fully
// pipelined chain: five stages evaluate the density cubic for both temperatures side by side,
// one stage forms the scaled numerator, twenty stages of a restoring divider produce one quotient
// bit each, and one output register holds the result. One request is taken every cycle while
// req_stall is low. When the result side stalls, a one-entry skid stage catches the item in
// flight and req_stall rises until it drains. The csr register must be written only while no
// transfer is in progress; the block itself does not enforce this.
module gravity_temperature_correction_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gtc_pkg::grav_type req_gravity_in,
   input  gtc_pkg::temp_type req_temp_c,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gtc_pkg::grav_type rsp_gravity_out,
   output logic              rsp_saturated,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  gtc_pkg::temp_type csr_cal_temp_c
);
   import gtc_pkg::*;

   temp_type cal_ff;

   logic     en;
   logic     accept;

   logic [POLY_LAT-1:0] pvld_ff;
   grav_type            gdly_ff [POLY_LAT];

   poly_type pt, pc;

   logic     nvld_ff;
   num_type  num_ff, num_in;
   poly_type den_ff;

   logic     dvld;
   quo_type  quo;
   logic     push;
   logic     res_sat;
   grav_type res_grav;

   logic     out_vld_ff, out_vld_in;
   grav_type out_grav_ff, out_grav_in;
   logic     out_sat_ff, out_sat_in;
   logic     sk_vld_ff, sk_vld_in;
   grav_type sk_grav_ff, sk_grav_in;
   logic     sk_sat_ff, sk_sat_in;

   assign csr_ready = 1'b1;
   assign en        = !sk_vld_ff;
   assign req_stall = sk_vld_ff;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= CAL_RESET;
      end else if (csr_valid && csr_ready) begin
         cal_ff <= csr_cal_temp_c;
      end
   end

   gtc_poly u_poly_temp (
      .clock  (clock),
      .en     (en),
      .temp_c (req_temp_c),
      .poly   (pt)
   );

   gtc_poly u_poly_cal (
      .clock  (clock),
      .en     (en),
      .temp_c (cal_ff),
      .poly   (pc)
   );

   assign num_in = NW'(gdly_ff[POLY_LAT-1]) * NW'(pt) + NW'(pc >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= '0;
         nvld_ff <= 1'b0;
      end else if (en) begin
         pvld_ff <= {pvld_ff[POLY_LAT-2:0], accept};
         nvld_ff <= pvld_ff[POLY_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gdly_ff[0] <= req_gravity_in;
         for (int k = 1; k < POLY_LAT; k++) begin
            gdly_ff[k] <= gdly_ff[k-1];
         end
         num_ff <= num_in;
         den_ff <= pc;
      end
   end

   gtc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (nvld_ff),
      .num       (num_ff),
      .den       (den_ff),
      .out_valid (dvld),
      .quo       (quo)
   );

   assign push     = en && dvld;
   assign res_sat  = |quo[QW-1:GW];
   assign res_grav = res_sat ? GMAX : quo[GW-1:0];

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_grav_in = out_grav_ff;
      out_sat_in  = out_sat_ff;
      sk_vld_in   = sk_vld_ff;
      sk_grav_in  = sk_grav_ff;
      sk_sat_in   = sk_sat_ff;
      if (!out_vld_ff || !rsp_stall) begin
         if (sk_vld_ff) begin
            out_vld_in  = 1'b1;
            out_grav_in = sk_grav_ff;
            out_sat_in  = sk_sat_ff;
            sk_vld_in   = 1'b0;
         end else begin
            out_vld_in  = push;
            out_grav_in = res_grav;
            out_sat_in  = res_sat;
         end
      end else if (push) begin
         sk_vld_in  = 1'b1;
         sk_grav_in = res_grav;
         sk_sat_in  = res_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         sk_vld_ff  <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
         sk_vld_ff  <= sk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_grav_ff <= out_grav_in;
      out_sat_ff  <= out_sat_in;
      sk_grav_ff  <= sk_grav_in;
      sk_sat_ff   <= sk_sat_in;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_gravity_out = out_grav_ff;
   assign rsp_saturated   = out_sat_ff;

   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      sk_vld_ff |-> out_vld_ff)
      else $error("Skid stage holds a transfer while the output register is empty.");

   a_skid_fills_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(sk_vld_ff) |-> $past(out_vld_ff && rsp_stall))
      else $error("Skid stage filled while the output register was free.");

   a_sat_clips: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_sat_ff) |-> (out_grav_ff == GMAX))
      else $error("Saturated result is not clipped to the full-scale value.");

endmodule

// ===== bench/gtc_correction_checker.sv =====
// Checker for the gravity temperature correction core: predicts each corrected reading and compares.
module gtc_correction_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  gtc_pkg::grav_type req_gravity_in,
   input  gtc_pkg::temp_type req_temp_c,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  gtc_pkg::grav_type rsp_gravity_out,
   input  logic              rsp_saturated,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  gtc_pkg::temp_type csr_cal_temp_c,
   output int                mismatches,
   output int                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import gtc_pkg::*;

   typedef struct packed {
      grav_type gravity;
      logic     saturated;
   } corrected_type;

   function automatic longint round_ratio(longint unsigned num, int hi, int lo,
                                          longint unsigned den);
      longint unsigned d;
      d = num << hi;
      return longint'(((d / den) << lo) + (((d % den) << lo) + den / 2) / den);
   endfunction

   localparam longint K0 = round_ratio(64'd100130346, 22, 0, 64'd390625);
   localparam longint K1 = round_ratio(64'd134722124, 28, 0, 64'd244140625);
   localparam longint K2 = round_ratio(64'd204052596, 34, 0, 64'd6103515625);
   localparam longint K3 = round_ratio(64'd232820948, 20, 19, 64'd762939453125);

   function automatic longint round_shift(longint x, int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint fahrenheit_q8(temp_type c);
      longint v;
      v = 9 * longint'(c) + 327680;
      return (v + 2) / 5 - 65536 + 8192;
   endfunction

   function automatic longint density_q30(temp_type c);
      longint f, h2, h1;
      f  = fahrenheit_q8(c);
      h2 = K2 - round_shift(K3 * f, 16);
      h1 = round_shift(f * h2, 16) - K1;
      return K0 + round_shift(f * h1, 18);
   endfunction

   function automatic corrected_type correct_gravity(grav_type g, temp_type t, temp_type cal);
      corrected_type r;
      longint pt, pc, q;
      pt = density_q30(t);
      pc = density_q30(cal);
      r.gravity   = GMAX;
      r.saturated = 1'b1;
      if (pc > 0 && pt >= 0) begin
         q = (longint'(g) * pt + pc / 2) / pc;
         if (q <= longint'(GMAX)) begin
            r.gravity   = grav_type'(q);
            r.saturated = 1'b0;
         end
      end
      return r;
   endfunction

   corrected_type corrected_q[$];
   temp_type      cal_copy = CAL_RESET;
   corrected_type want;

   always @(posedge clock) begin
      if (reset) begin
         corrected_q.delete();
         cal_copy   = CAL_RESET;
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) cal_copy = csr_cal_temp_c;
         if (req_valid && !req_stall)
            corrected_q.push_back(correct_gravity(req_gravity_in, req_temp_c, cal_copy));
         if (rsp_valid && !rsp_stall) begin
            if (corrected_q.size() == 0) begin
               $display("%0t: unexpected result gravity_out %0d saturated %0b", $time,
                        rsp_gravity_out, rsp_saturated);
               mismatches = mismatches + 1;
            end else begin
               want = corrected_q.pop_front();
               if (rsp_gravity_out !== want.gravity) begin
                  $display("%0t: gravity_out expected %0d actual %0d", $time,
                           want.gravity, rsp_gravity_out);
                  mismatches = mismatches + 1;
               end
               if (rsp_saturated !== want.saturated) begin
                  $display("%0t: saturated expected %0b actual %0b", $time,
                           want.saturated, rsp_saturated);
                  mismatches = mismatches + 1;
               end
            end
         end
      end
      outstanding <= corrected_q.size();
   end

endmodule

// ===== bench/testbench.sv =====
// Top of the testbench: drives readings and calibration writes into the core and gives the verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import gtc_pkg::*;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   grav_type req_gravity_in = '0;
   temp_type req_temp_c = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   grav_type rsp_gravity_out;
   logic     rsp_saturated;
   logic     csr_valid = 1'b0;
   logic     csr_ready;
   temp_type csr_cal_temp_c = '0;

   int mismatches;
   int outstanding;
   int send_idle = 0;
   int recv_idle = 0;

   gravity_temperature_correction_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_gravity_in  (req_gravity_in),
      .req_temp_c      (req_temp_c),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_gravity_out (rsp_gravity_out),
      .rsp_saturated   (rsp_saturated),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_cal_temp_c  (csr_cal_temp_c)
   );

   gtc_correction_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_gravity_in  (req_gravity_in),
      .req_temp_c      (req_temp_c),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_gravity_out (rsp_gravity_out),
      .rsp_saturated   (rsp_saturated),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_cal_temp_c  (csr_cal_temp_c),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < recv_idle);

   task automatic send_reading(grav_type g, temp_type t);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_gravity_in <= g;
      req_temp_c     <= t;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random_reading();
      grav_type g;
      temp_type t;
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) g = grav_type'($urandom_range(78643, 64880));
      else if (pick < 85) g = grav_type'($urandom);
      else g = grav_type'($urandom_range(262143, 250000));
      if ($urandom_range(99) < 70) t = temp_type'(int'($urandom_range(40960)) - 10240);
      else t = temp_type'($urandom);
      send_reading(g, t);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_cal(temp_type v);
      drain();
      repeat (30) @(posedge clock);
      csr_valid      <= 1'b1;
      csr_cal_temp_c <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      #2000000;
      $display("testbench failed");
      $finish;
   end

   initial begin
      temp_type cal_list[6];
      cal_list = '{16'sd30720, -16'sd10240, -16'sd32768, 16'sd32767, 16'sd0, 16'sd0};
      cal_list[5] = temp_type'(int'($urandom_range(40960)) - 10240);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_reading(18'd0, 16'sd5120);
      send_reading(18'd1, 16'sd5120);
      send_reading(18'd65536, 16'sd5120);
      send_reading(GMAX, 16'sd5120);
      send_reading(18'd65536, -16'sd10240);
      send_reading(18'd65536, 16'sd30720);
      send_reading(GMAX, 16'sd30720);
      send_reading(GMAX, -16'sd10240);
      send_reading(GMAX, -16'sd32768);
      send_reading(GMAX, 16'sd32767);
      send_reading(18'd0, -16'sd32768);
      send_reading(18'd65536, 16'sd32767);
      send_reading(18'd65536, -16'sd32768);
      send_reading(18'd70000, 16'sd0);
      send_reading(18'd131072, -16'sd1);
      send_reading(18'd262142, 16'sd32767);
      send_reading(18'd200000, 16'sd2560);
      send_reading(18'd98304, 16'sd25600);

      for (int p = 0; p < 3; p++) begin
         send_idle = (p == 0) ? 8 : (p == 1) ? 57 : 0;
         recv_idle = (p == 0) ? 57 : (p == 1) ? 8 : 0;
         for (int s = 0; s < 2; s++) begin
            write_cal(cal_list[2 * p + s]);
            for (int i = 0; i < 80; i++) begin
               if (p == 0 && s == 0 && i == 40) drain();
               send_random_reading();
            end
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
